>>> src/dtfp_pkg.sv
// Shared types and constants for the decimal text to fixed point converter.
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 5;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // counters stick at their top value
   localparam logic [COUNT_W-1:0] COUNT_TOP = 5'd31;

   // fraction positions held in the weight lookup; deeper positions weigh zero
   localparam int FRAC_POS_N    = 32;
   localparam int WEIGHT_POS_N  = 19;

   localparam logic [63:0] POW10 [20] = '{
      64'd1, 64'd10, 64'd100, 64'd1000,
      64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000,
      64'd10000000000, 64'd100000000000,
      64'd1000000000000, 64'd10000000000000,
      64'd100000000000000, 64'd1000000000000000,
      64'd10000000000000000, 64'd100000000000000000,
      64'd1000000000000000000, 64'd10000000000000000000
   };

   typedef struct packed {
      logic is_negative;
      logic overflowed;
   } sign_flags_type;

endpackage

`default_nettype wire

>>> src/decimal_text_to_fixed_point_unit.sv
// Top level: ASCII decimal text in, signed fixed point number out.
//
// Usage: feed one ASCII character per beat on the req_ stream. Digits before
// a '.' or ',' build the integer part, each '-' there flips the sign, and
// digits after the point add their decimal weight in FRAC_BITS fraction bits.
// A NUL beat closes the number (the NUL itself is not counted), as does the
// MAX_CHARS-th non-NUL character. Each closed number leaves as one rsp_ beat:
// rsp_tdata carries the two's complement value, rsp_tuser flags clamping.
// Throughput: one character per cycle while req_tready is high; the accumulate
// step is a constant multiply-by-ten and one digit-weight product, combinational.
// A closing beat is registered in the snapshot at the accepting edge, then in
// the magnitude stage with clamp, then in the sign stage that drives rsp_tvalid.
// Reset clears the partial number and empties the result pipeline.
// When the receiver stalls, up to three results are held in the pipeline;
// req_tready falls only once a result is waiting in every stage.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_point_unit #(
   parameter int MAX_CHARS = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] char_code
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // [63:0] value
   output logic              rsp_tuser    // [0] saturated
);
   import dtfp_pkg::*;

   localparam int WHOLE_W = 63 - FRAC_BITS;
   localparam int FRAC_W  = FRAC_BITS + 1;
   localparam int MAG_W   = VALUE_W - 1;

   logic                 p_valid, p_ready;
   logic [WHOLE_W-1:0]   p_whole;
   logic [FRAC_W-1:0]    p_frac;
   sign_flags_type       p_flags;

   dtfp_parse #(
      .MAX_CHARS (MAX_CHARS),
      .FRAC_BITS (FRAC_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_char   (req_tdata),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_whole (p_whole),
      .out_frac  (p_frac),
      .out_flags (p_flags)
   );

   logic               mag_valid_ff;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               mag_neg_ff;
   logic               mag_sat_ff, mag_sat_in;
   logic [VALUE_W-1:0] mag_sum;

   logic               out_valid_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               sat_ff;

   logic               out_ready, mag_ready;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign mag_ready = !mag_valid_ff || out_ready;
   assign p_ready   = mag_ready;

   // whole shifted into place plus fraction; the fraction may carry into the whole
   assign mag_sum    = {1'b0, p_whole, {FRAC_BITS{1'b0}}} + VALUE_W'(p_frac);
   assign mag_sat_in = p_flags.overflowed || mag_sum[VALUE_W-1];
   assign mag_in     = mag_sum[VALUE_W-1] ? {MAG_W{1'b1}} : mag_sum[MAG_W-1:0];

   assign value_in = mag_neg_ff ? (VALUE_W'(0) - {1'b0, mag_ff}) : {1'b0, mag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (mag_ready) begin
         mag_valid_ff <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mag_ready && p_valid) begin
         mag_ff     <= mag_in;
         mag_neg_ff <= p_flags.is_negative;
         mag_sat_ff <= mag_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= mag_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mag_valid_ff) begin
         value_ff <= value_in;
         sat_ff   <= mag_sat_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = sat_ff;

endmodule

`default_nettype wire

>>> src/dtfp_parse.sv
// Character decoder and running accumulator; snapshots a finished number.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_parse #(
   parameter int MAX_CHARS = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [dtfp_pkg::CHAR_W-1:0]   in_char,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [62-FRAC_BITS:0]              out_whole,
   output logic [FRAC_BITS:0]                 out_frac,
   output dtfp_pkg::sign_flags_type           out_flags
);
   import dtfp_pkg::*;

   localparam int WHOLE_W = 63 - FRAC_BITS;
   localparam int FRAC_W  = FRAC_BITS + 1;
   localparam int MUL_W   = WHOLE_W + 4;
   localparam int FSUM_W  = FRAC_BITS + 5;
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(MAX_CHARS);

   logic [FRAC_BITS-1:0] weight_tab [FRAC_POS_N];

   // weight of position k is round(2^FRAC_BITS / 10^k), entry k-1
   for (genvar i = 0; i < FRAC_POS_N; i++) begin : g_weight
      if (i < WEIGHT_POS_N) begin : g_tab
         localparam logic [63:0] WT =
            (((64'd1 << (FRAC_BITS + 1)) / POW10[i + 1]) + 64'd1) >> 1;
         assign weight_tab[i] = WT[FRAC_BITS-1:0];
      end else begin : g_zero
         assign weight_tab[i] = '0;
      end
   end

   logic [WHOLE_W-1:0] whole_ff, whole_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [COUNT_W-1:0] fdig_ff, fdig_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               after_ff, after_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;

   logic                  snap_valid_ff;
   logic [WHOLE_W-1:0]    snap_whole_ff, snap_whole_in;
   logic [FRAC_W-1:0]     snap_frac_ff, snap_frac_in;
   sign_flags_type        snap_flags_ff, snap_flags_in;

   logic               is_digit, is_nul, count_full, take, done;
   logic [3:0]         digit;
   logic [MUL_W-1:0]   whole_mul;
   logic               whole_over;
   logic [FSUM_W-1:0]  frac_prod, frac_sum;
   logic               frac_over;

   assign in_ready   = !snap_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign is_nul     = (in_char == CHAR_NUL);
   assign is_digit   = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
   assign digit      = is_digit ? in_char[3:0] : 4'd0;

   // whole * 10 + digit; any bit above the field means clamp
   assign whole_mul  = (MUL_W'(whole_ff) << 3) + (MUL_W'(whole_ff) << 1) + MUL_W'(digit);
   assign whole_over = |whole_mul[MUL_W-1:WHOLE_W];

   assign frac_prod  = FSUM_W'(digit) * FSUM_W'(weight_tab[fdig_ff]);
   assign frac_sum   = FSUM_W'(frac_ff) + frac_prod;
   assign frac_over  = |frac_sum[FSUM_W-1:FRAC_W];

   always_comb begin
      whole_in = whole_ff;
      frac_in  = frac_ff;
      fdig_in  = fdig_ff;
      after_in = after_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      if (!after_ff) begin
         if (is_digit) begin
            if (whole_over) begin
               whole_in = '1;
               ovf_in   = 1'b1;
            end else begin
               whole_in = whole_mul[WHOLE_W-1:0];
            end
         end else if (in_char == CHAR_POINT || in_char == CHAR_COMMA) begin
            after_in = 1'b1;
            fdig_in  = '0;
         end else if (in_char == CHAR_MINUS) begin
            neg_in = !neg_ff;
         end
      end else begin
         if (is_digit) begin
            frac_in = frac_over ? '1 : frac_sum[FRAC_W-1:0];
         end
         if (fdig_ff != COUNT_TOP) begin
            fdig_in = fdig_ff + 1'b1;
         end
      end
      cnt_in = (cnt_ff != COUNT_TOP) ? cnt_ff + 1'b1 : cnt_ff;
   end

   assign count_full = (cnt_in >= LAST_COUNT);
   assign done       = is_nul || count_full;

   // a NUL closes the number as it stands; a full count closes it after this char
   always_comb begin
      if (is_nul) begin
         snap_whole_in = whole_ff;
         snap_frac_in  = frac_ff;
         snap_flags_in = '{is_negative: neg_ff, overflowed: ovf_ff};
      end else begin
         snap_whole_in = whole_in;
         snap_frac_in  = frac_in;
         snap_flags_in = '{is_negative: neg_in, overflowed: ovf_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff <= '0;
         frac_ff  <= '0;
         fdig_ff  <= '0;
         cnt_ff   <= '0;
         after_ff <= 1'b0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (take) begin
         if (done) begin
            whole_ff <= '0;
            frac_ff  <= '0;
            fdig_ff  <= '0;
            cnt_ff   <= '0;
            after_ff <= 1'b0;
            neg_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
         end else begin
            whole_ff <= whole_in;
            frac_ff  <= frac_in;
            fdig_ff  <= fdig_in;
            cnt_ff   <= cnt_in;
            after_ff <= after_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (take && done) begin
         snap_valid_ff <= 1'b1;
      end else if (out_ready) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && done) begin
         snap_whole_ff <= snap_whole_in;
         snap_frac_ff  <= snap_frac_in;
         snap_flags_ff <= snap_flags_in;
      end
   end

   assign out_valid = snap_valid_ff;
   assign out_whole = snap_whole_ff;
   assign out_frac  = snap_frac_ff;
   assign out_flags = snap_flags_ff;

endmodule

`default_nettype wire

>>> src/dtfp_checker.sv
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // magnitude clamps at 2^63-1, so the most negative code never appears
   a_no_min_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 64'h8000_0000_0000_0000)
      else $error("result holds the most negative code");

   a_ready_when_drained: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the output stage empty");

   a_nul_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata == 8'h00) ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("closed number did not reach the output in time");

endmodule

bind decimal_text_to_fixed_point_unit dtfp_checker u_dtfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
